/* hdl/sparse_row_sorted_insert_unit_defines.svh */
// Assertion helpers for the sorted insert unit.
`ifndef SPARSE_ROW_SORTED_INSERT_UNIT_DEFINES_SVH
`define SPARSE_ROW_SORTED_INSERT_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRSI_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRSI_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/srsi_pkg.sv */
`timescale 1ns / 1ps
package srsi_pkg;

  localparam int ROW_W  = 9;
  localparam int COL_W  = 13;
  localparam int DATA_W = 32;
  localparam int CNT_OUT_W = 11;

  localparam logic REG_ROWS_IN_USE = 1'b0;
  localparam logic REG_COLS_IN_USE = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED    = 3'd0,
    ST_DUPLICATE   = 3'd1,
    ST_ACCUMULATED = 3'd2,
    ST_FULL        = 3'd3,
    ST_RANGE       = 3'd4
  } status_t;

  // Token phase as it travels the chain.
  typedef enum logic [1:0] {
    TK_SEARCH,  // look for the key, insert when passed
    TK_PROBE,   // store full: look for the key, never insert
    TK_SHIFT,   // carry a displaced entry toward the tail
    TK_DONE     // finished, ride to the end
  } tok_state_t;

  typedef struct packed {
    logic                vld;
    tok_state_t          st;
    logic                mode;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [DATA_W-1:0]   data;
    status_t             status;
  } tok_t;

endpackage

/* hdl/srsi_cell.sv */
`timescale 1ns / 1ps
module srsi_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  srsi_pkg::tok_t tok_in,
  output srsi_pkg::tok_t tok_out
);
  import srsi_pkg::*;

  logic              vld_r, vld_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  tok_t              tok_r, tok_nxt;
  logic              key_eq, key_gt;

  assign key_eq = ({row_r, col_r} == {tok_in.row, tok_in.col});
  assign key_gt = ({row_r, col_r} >  {tok_in.row, tok_in.col});

  always_comb begin
    vld_nxt  = vld_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    data_nxt = data_r;
    tok_nxt  = tok_in;
    if (tok_in.vld) begin
      unique case (tok_in.st)
        TK_SEARCH, TK_PROBE: begin
          if (!vld_r) begin
            if (tok_in.st == TK_PROBE) begin
              tok_nxt.status = ST_FULL;
            end else begin
              vld_nxt  = 1'b1;
              row_nxt  = tok_in.row;
              col_nxt  = tok_in.col;
              data_nxt = tok_in.data;
              tok_nxt.status = ST_INSERTED;
            end
            tok_nxt.st = TK_DONE;
          end else if (key_eq) begin
            if (tok_in.mode) begin
              data_nxt = data_r + tok_in.data;
              tok_nxt.status = ST_ACCUMULATED;
            end else begin
              tok_nxt.status = ST_DUPLICATE;
            end
            tok_nxt.st = TK_DONE;
          end else if (key_gt) begin
            if (tok_in.st == TK_PROBE) begin
              tok_nxt.status = ST_FULL;
              tok_nxt.st     = TK_DONE;
            end else begin
              row_nxt  = tok_in.row;
              col_nxt  = tok_in.col;
              data_nxt = tok_in.data;
              tok_nxt.row    = row_r;
              tok_nxt.col    = col_r;
              tok_nxt.data   = data_r;
              tok_nxt.status = ST_INSERTED;
              tok_nxt.st     = TK_SHIFT;
            end
          end
        end
        TK_SHIFT: begin
          vld_nxt  = 1'b1;
          row_nxt  = tok_in.row;
          col_nxt  = tok_in.col;
          data_nxt = tok_in.data;
          if (!vld_r) begin
            tok_nxt.st = TK_DONE;
          end else begin
            tok_nxt.row  = row_r;
            tok_nxt.col  = col_r;
            tok_nxt.data = data_r;
          end
        end
        TK_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    data_r       <= data_nxt;
    tok_r.st     <= tok_nxt.st;
    tok_r.mode   <= tok_nxt.mode;
    tok_r.row    <= tok_nxt.row;
    tok_r.col    <= tok_nxt.col;
    tok_r.data   <= tok_nxt.data;
    tok_r.status <= tok_nxt.status;
  end

  assign tok_out = tok_r;

endmodule

/* hdl/sparse_row_sorted_insert_unit.sv */
`timescale 1ns / 1ps
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_tvalid/tready   | tuser mode, tdata row/col/value
// out_    | out | out_tvalid/tready  | tdata status, nonzero count
// cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// Each item's token walks the cell chain one cell per cycle, whatever the
// outcome, and its result beat is then registered in the result buffer.
// One item is in the chain at a time; in_tready drops while it walks.
// A two-deep result buffer lets the next item start while a result waits.
// Reset (rst_n low, synchronous) empties every cell at once; no sweep.
// A stalled output side blocks new input only once both result slots fill.
module sparse_row_sorted_insert_unit #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 4096,
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // row_index[8:0], col_index[21:9], entry_value[53:22]
  input  logic [0:0]  in_tuser,   // mode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status[2:0], nonzero_count[13:3]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);
  import srsi_pkg::*;
  `include "sparse_row_sorted_insert_unit_defines.svh"

  localparam int CW = $clog2(CAPACITY + 1);

  // Register file
  logic [ROW_W-1:0] rows_r;
  logic [COL_W-1:0] cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROW_W'(256);
      cols_r <= COL_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS_IN_USE: rows_r <= cfg_wdata[ROW_W-1:0];
        REG_COLS_IN_USE: cols_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input decode and range check
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [DATA_W-1:0] in_val;
  logic              in_acc, out_of_range;
  logic              busy_r, busy_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              full;

  assign in_row = in_tdata[8:0];
  assign in_col = in_tdata[21:9];
  assign in_val = in_tdata[53:22];
  assign in_acc = in_tvalid && in_tready;
  assign full   = (count_r == CW'(CAPACITY));

  assign out_of_range = (in_row == '0) || (in_row > rows_r) ||
                        (32'(in_row) > 32'(MAX_ROWS)) ||
                        (in_col == '0) || (in_col > cols_r) ||
                        (32'(in_col) > 32'(MAX_COLS));

  // Cell chain
  tok_t chain [CAPACITY+1];
  tok_t head_tok;

  // A probe that passes every cell means the key is new and the store is
  // full, so it starts out marked full.
  always_comb begin
    head_tok.vld  = in_acc;
    head_tok.mode = in_tuser[0];
    head_tok.row  = in_row;
    head_tok.col  = in_col;
    head_tok.data = in_val;
    if (out_of_range) begin
      head_tok.st     = TK_DONE;
      head_tok.status = ST_RANGE;
    end else if (full) begin
      head_tok.st     = TK_PROBE;
      head_tok.status = ST_FULL;
    end else begin
      head_tok.st     = TK_SEARCH;
      head_tok.status = ST_INSERTED;
    end
  end

  assign chain[0] = head_tok;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    srsi_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  // Token leaves the tail: settle the count and build the result beat
  logic          exit_vld;
  logic [15:0]   res_beat;

  assign exit_vld  = chain[CAPACITY].vld;
  assign count_nxt = (exit_vld && chain[CAPACITY].status == ST_INSERTED) ?
                     count_r + CW'(1) : count_r;
  assign res_beat  = {2'b00, CNT_OUT_W'(count_nxt), chain[CAPACITY].status};

  always_comb begin
    busy_nxt = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (exit_vld) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      count_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      count_r <= count_nxt;
    end
  end

  // Result buffer: output register plus one hold slot
  logic        out_valid_r, hold_valid_r;
  logic [15:0] out_data_r, hold_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else if (out_valid_r && !out_tready) begin
      // hold the output; park a fresh result
      if (exit_vld) begin
        hold_valid_r <= 1'b1;
      end
    end else if (hold_valid_r) begin
      out_valid_r  <= 1'b1;
      hold_valid_r <= exit_vld;
    end else begin
      out_valid_r <= exit_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_tready) begin
      if (exit_vld) begin
        hold_data_r <= res_beat;
      end
    end else if (hold_valid_r) begin
      out_data_r <= hold_data_r;
      if (exit_vld) begin
        hold_data_r <= res_beat;
      end
    end else if (exit_vld) begin
      out_data_r <= res_beat;
    end
  end

  assign in_tready  = !busy_r && !hold_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SRSI_AST_NEXT(a_accept_busy, in_acc, busy_r, "accepted beat did not mark chain busy")
  `SRSI_AST_NOW(a_exit_busy, exit_vld, busy_r, "token left the chain while idle")
  `SRSI_AST_NOW(a_hold_order, hold_valid_r, out_valid_r, "hold slot filled ahead of output")
  `SRSI_AST_NOW(a_count_cap, 1'b1, count_r <= CW'(CAPACITY), "entry count above capacity")

endmodule
